/* rtl/core/int32_to_float32_convert_top_macros.svh */
// ----------------------------------------------------------------------------
// int32_to_float32_convert_top_macros.svh
// Assertion helpers shared by the converter's checker.
// ----------------------------------------------------------------------------
`ifndef INT32_TO_FLOAT32_CONVERT_TOP_MACROS_SVH
`define INT32_TO_FLOAT32_CONVERT_TOP_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define I2F_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication, switched off while reset is asserted
`define I2F_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/core/i2f_pkg.sv */
// ----------------------------------------------------------------------------
// i2f_pkg
// Widths, IEEE 754 single constants and types for the integer to float
// converter.
// ----------------------------------------------------------------------------
package i2f_pkg;

	localparam int WORD_W    = 32;
	localparam int EXP_W     = 8;
	localparam int FRAC_BITS = 23;
	localparam int SIGN_POS  = 31;
	localparam int MSB_W     = 5;

	// Exponent bias and the largest exponent an int32 can reach (2^31)
	localparam logic [EXP_W-1:0] FLT_BIAS = 8'd127;
	localparam logic [EXP_W-1:0] EXP_MAX  = 8'd158;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [MSB_W-1:0]  msb_t;

endpackage

/* rtl/core/i2f_int_if.sv */
// ----------------------------------------------------------------------------
// i2f_int_if
// Valid/ready channel carrying one signed 32-bit integer per item.
// ----------------------------------------------------------------------------
interface i2f_int_if import i2f_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] int_value;

	modport source (output valid, output int_value, input ready);
	modport sink   (input valid, input int_value, output ready);

endinterface

/* rtl/core/i2f_float_if.sv */
// ----------------------------------------------------------------------------
// i2f_float_if
// Valid/ready channel carrying one IEEE 754 single bit pattern per item.
// ----------------------------------------------------------------------------
interface i2f_float_if import i2f_pkg::*; ();

	logic  valid;
	logic  ready;
	word_t float_word;

	modport source (output valid, output float_word, input ready);
	modport sink   (input valid, input float_word, output ready);

endinterface

/* rtl/core/int32_to_float32_convert_top.sv */
// Throughput: one item per cycle while the output is not stalled; each of
// the three stages holds one item.
// Stage 1 takes sign and magnitude, stage 2 finds the leading one and
// normalises, stage 3 rounds to nearest even and packs the result register.
// Reset clears the stage valid bits only; the pipeline comes up empty.
// ----------------------------------------------------------------------------
// int32_to_float32_convert_top
// Signed 32-bit integer to IEEE 754 single, round to nearest even,
// three-stage pipeline with per-stage valid/ready back-pressure.
// ----------------------------------------------------------------------------
module int32_to_float32_convert_top import i2f_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	i2f_int_if.sink        sample,
	i2f_float_if.source    result
);

	// Stage registers
	logic               v_s1, v_s2, v_s3;
	logic               sign_s1, sign_s2;
	logic               zero_s1, zero_s2;
	word_t              mag_s1;
	word_t              norm_s2;
	msb_t               msb_s2;
	word_t              word_s3;

	logic               rdy1, rdy2, rdy3;

	// Stage moves when it is empty or the next stage takes its item
	assign rdy3         = !v_s3 || result.ready;
	assign rdy2         = !v_s2 || rdy3;
	assign rdy1         = !v_s1 || rdy2;
	assign sample.ready = rdy1;

	// Stage 1: split sign and magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && rdy1) begin
			sign_s1 <= sample.int_value[SIGN_POS];
			zero_s1 <= (sample.int_value == '0);
			mag_s1  <= sample.int_value[SIGN_POS] ? word_t'(-sample.int_value)
			                                       : word_t'(sample.int_value);
		end
	end

	// Stage 2: locate the leading one and left-align it to the top bit
	msb_t  lead;
	word_t norm;

	always_comb begin
		lead = '0;
		for (int k = 0; k < WORD_W; k++) begin
			if (mag_s1[k]) begin
				lead = msb_t'(k);
			end
		end
		norm = mag_s1 << (msb_t'(WORD_W - 1) - lead);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			sign_s2 <= sign_s1;
			zero_s2 <= zero_s1;
			msb_s2  <= lead;
			norm_s2 <= norm;
		end
	end

	// Stage 3: round to nearest even, carry ripples into the exponent
	logic [FRAC_BITS-1:0]       frac;
	logic                       guard_bit, sticky, round_up;
	logic [EXP_W-1:0]           expo;
	logic [WORD_W-2:0]          packed_mag;

	always_comb begin
		frac       = norm_s2[WORD_W-2 -: FRAC_BITS];
		guard_bit  = norm_s2[WORD_W-2-FRAC_BITS];
		sticky     = |norm_s2[WORD_W-3-FRAC_BITS:0];
		round_up   = guard_bit && (sticky || frac[0]);
		expo       = FLT_BIAS + EXP_W'(msb_s2);
		packed_mag = {expo, frac} + (WORD_W-1)'(round_up);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			word_s3 <= zero_s2 ? '0 : {sign_s2, packed_mag};
		end
	end

	assign result.valid      = v_s3;
	assign result.float_word = word_s3;

endmodule

/* rtl/core/i2f_checker.sv */
// ----------------------------------------------------------------------------
// i2f_checker
// Port-level checks on the converter: latency bound, back-pressure and
// shape of the results.
// ----------------------------------------------------------------------------
`include "int32_to_float32_convert_top_macros.svh"

module i2f_checker import i2f_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input word_t out_float_word
);

	// Hold a stalled result
	`I2F_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 (out_valid && $stable(out_float_word)), "stalled result changed")

	// An accepted item is followed by a valid result on the output
	`I2F_ASSERT_IMP(a_latency, in_valid && in_ready, ##3 out_valid, "result missing after accepted item")

	// An empty output stage never blocks the input
	`I2F_ASSERT_IMP(a_no_block, !out_valid, in_ready, "input blocked with empty output")

	// No denormals: a zero exponent means the whole word is zero
	`I2F_ASSERT_IMP(a_no_denorm, out_valid && (out_float_word[WORD_W-2 -: EXP_W] == '0), out_float_word == '0, "nonzero result with zero exponent")

	// Exponent stays within the int32 range
	`I2F_ASSERT(a_exp_range, !out_valid || (out_float_word[WORD_W-2 -: EXP_W] <= EXP_MAX), "exponent out of range")

endmodule

bind int32_to_float32_convert_top i2f_checker u_i2f_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sample.valid),
	.in_ready       (sample.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_float_word (result.float_word)
);

/* verif/int32_to_float32_convert_top_tb.sv */
// ----------------------------------------------------------------------------
// int32_to_float32_convert_top_tb
// Self-checking bench for the integer to IEEE 754 single converter. Items are
// driven on the sample channel with random gaps and random result stalls.
// Every accepted integer is converted by a local round-to-nearest-even
// predictor, and each returned float word is checked in order against it.
// ----------------------------------------------------------------------------
module int32_to_float32_convert_top_tb;
	import i2f_pkg::*;

	localparam int PIPE_LATENCY = 3;
	localparam int RANDOM_ITEMS = 2000;
	localparam int REPORT_LIMIT = 10;

	logic clk;
	logic arst_n;

	i2f_int_if   sample_if ();
	i2f_float_if result_if ();

	int32_to_float32_convert_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if),
		.result (result_if)
	);

	word_t pending_floats[$];
	int    mismatch_count = 0;
	int    send_idle_pct  = 0;
	int    recv_idle_pct  = 0;

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold reset from time zero, release at a falling edge
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Give up after a generous fixed time
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	// Round-to-nearest-even conversion of one signed integer
	function automatic word_t float_of_int(input logic signed [WORD_W-1:0] value);
		logic [WORD_W-1:0] mag;
		logic [WORD_W-1:0] rest;
		logic [WORD_W-1:0] low_bits;
		logic [WORD_W-1:0] half;
		logic [FRAC_BITS-1:0] frac;
		logic [EXP_W-1:0] expo;
		word_t bits;
		int lead;
		int drop;
		logic neg;
		if (value == '0)
			return '0;
		if ($unsigned(value) == 32'h8000_0000)
			return {1'b1, EXP_MAX, {FRAC_BITS{1'b0}}};
		neg  = value[SIGN_POS];
		mag  = neg ? $unsigned(-value) : $unsigned(value);
		lead = 0;
		for (int k = 0; k < SIGN_POS; k++)
			if (mag[k])
				lead = k;
		expo = FLT_BIAS + EXP_W'(lead);
		rest = mag & ~(32'd1 << lead);
		if (lead <= FRAC_BITS) begin
			frac = FRAC_BITS'(rest << (FRAC_BITS - lead));
			bits = {1'b0, expo, frac};
		end else begin
			// Drop the low bits, then round; a carry spills into the exponent
			drop     = lead - FRAC_BITS;
			low_bits = rest & ((32'd1 << drop) - 32'd1);
			half     = 32'd1 << (drop - 1);
			frac     = FRAC_BITS'(rest >> drop);
			bits     = {1'b0, expo, frac};
			if (low_bits > half || (low_bits == half && frac[0]))
				bits = bits + 32'd1;
		end
		bits[SIGN_POS] = neg;
		return bits;
	endfunction

	// Random integer biased towards narrow magnitudes and rounding ties
	function automatic logic [WORD_W-1:0] random_int();
		logic [WORD_W-1:0] mag;
		logic [WORD_W-1:0] half;
		logic [WORD_W-1:0] low_mask;
		int width;
		int drop;
		mag = '0;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				return $urandom;
			end
			4, 5, 6: begin
				width = $urandom_range(1, 31);
				mag = ($urandom & ((32'd1 << width) - 32'd1)) | (32'd1 << (width - 1));
			end
			7, 8: begin
				// Wide magnitude with the dropped bits at, just below or just above the halfway point, or all set
				width    = $urandom_range(25, 31);
				drop     = width - 24;
				half     = 32'd1 << (drop - 1);
				low_mask = (32'd1 << drop) - 32'd1;
				mag = ($urandom & ((32'd1 << width) - 32'd1)) | (32'd1 << (width - 1));
				mag = mag & ~low_mask;
				case ($urandom_range(3))
					0: mag = mag | half;
					1: mag = mag | (half - 32'd1);
					2: mag = mag | ((half + 32'd1) & low_mask);
					default: mag = mag | low_mask;
				endcase
			end
			default: begin
				case ($urandom_range(3))
					0: mag = 32'h0000_0000;
					1: mag = 32'h8000_0000;
					2: mag = 32'h7FFF_FFFF;
					default: mag = 32'h0000_0001;
				endcase
			end
		endcase
		if ($urandom_range(1))
			mag = -mag;
		return mag;
	endfunction

	task automatic log_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Send one item, idling first at the current sender rate
	task automatic drive_int(input logic [WORD_W-1:0] value);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_if.valid <= 1'b0;
			@(negedge clk);
		end
		sample_if.valid     <= 1'b1;
		sample_if.int_value <= value;
		do
			@(posedge clk);
		while (!sample_if.ready);
	endtask

	// Stop sending and hold off until every expected float has come back
	task automatic wait_drained();
		@(negedge clk);
		sample_if.valid <= 1'b0;
		while (pending_floats.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// Receiver: stall at random at the current rate
	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Record accepted integers and check returned floats in order
	always @(posedge clk) begin
		word_t want;
		if (arst_n) begin
			if (sample_if.valid && sample_if.ready)
				pending_floats.push_back(float_of_int(sample_if.int_value));
			if (result_if.valid && result_if.ready) begin
				if (pending_floats.size() == 0) begin
					log_failure($sformatf("unexpected float_word %h", result_if.float_word));
				end else begin
					want = pending_floats.pop_front();
					if (result_if.float_word !== want)
						log_failure($sformatf("float_word expected %h got %h",
							want, result_if.float_word));
				end
			end
		end
	end

	// Zero, the most negative value, unit and full-scale magnitudes, the 24-bit boundary and alternating bits
	task automatic test_special_values();
		drive_int(32'h0000_0000);
		drive_int(32'h0000_0001);
		drive_int(32'hFFFF_FFFF);
		drive_int(32'h0000_0002);
		drive_int(32'h8000_0000);
		drive_int(32'h7FFF_FFFF);
		drive_int(32'h8000_0001);
		drive_int(32'h00FF_FFFF);
		drive_int(32'h0100_0000);
		drive_int(32'h5555_5555);
		drive_int(32'hAAAA_AAAA);
	endtask

	// Ties to even, values just past a tie, and carries into the exponent
	task automatic test_rounding_edges();
		drive_int(32'h0100_0001);
		drive_int(32'h0100_0003);
		drive_int(32'h01FF_FFFF);
		drive_int(32'h7FFF_FFC0);
		drive_int(32'h7FFF_FF80);
		drive_int(32'h4000_0040);
		drive_int(32'h4000_00C0);
		drive_int(32'h4000_0041);
		drive_int(32'hFEFF_FFFD);
		drive_int(32'h8000_0040);
	endtask

	// Random items under three idling patterns, drained between phases
	task automatic test_random_under_stalls();
		int phase_items;
		phase_items = RANDOM_ITEMS / 3;
		send_idle_pct = 12;
		recv_idle_pct = 68;
		repeat (phase_items) drive_int(random_int());
		wait_drained();
		send_idle_pct = 68;
		recv_idle_pct = 12;
		repeat (phase_items) drive_int(random_int());
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (RANDOM_ITEMS - 2 * phase_items) drive_int(random_int());
	endtask

	initial begin
		sample_if.valid     <= 1'b0;
		sample_if.int_value <= '0;
		@(posedge arst_n);
		test_special_values();
		test_rounding_edges();
		wait_drained();
		test_random_under_stalls();
		wait_drained();
		if (pending_floats.size() != 0)
			log_failure($sformatf("%0d expected floats never arrived",
				pending_floats.size()));
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/i2f_pkg.sv
rtl/core/i2f_int_if.sv
rtl/core/i2f_float_if.sv
rtl/core/int32_to_float32_convert_top.sv
rtl/core/i2f_checker.sv
verif/int32_to_float32_convert_top_tb.sv
